[hdl/sar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sar_pkg: shared types and constants of the scroll address register unit
// Command codes, register offsets, controller state and the command struct.
// ----------------------------------------------------------------------------
package sar_pkg;

	localparam int unsigned AddrW = 15;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_READ    = 2'd1,
		CMD_COARSEX = 2'd2,
		CMD_INCY    = 2'd3
	} command_t;

	localparam logic [4:0] OFF_CONTROL = 5'h00;
	localparam logic [4:0] OFF_MASK    = 5'h01;
	localparam logic [4:0] OFF_STATUS  = 5'h02;
	localparam logic [4:0] OFF_OAMADDR = 5'h03;
	localparam logic [4:0] OFF_OAMDATA = 5'h04;
	localparam logic [4:0] OFF_SCROLL  = 5'h05;
	localparam logic [4:0] OFF_ADDRESS = 5'h06;
	localparam logic [4:0] OFF_DATA    = 5'h07;
	localparam logic [4:0] OFF_DMA     = 5'h14;

	typedef enum logic {
		ST_EMPTY = 1'b0,
		ST_FULL  = 1'b1
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
	} dp_cmd_t;

endpackage : sar_pkg
`default_nettype wire

[hdl/sar_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sar_ctrl: handshake controller
// Tracks whether the result register holds a word and issues the load command.
// ----------------------------------------------------------------------------
module sar_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sar_pkg::dp_cmd_t     cmd
);
	import sar_pkg::*;

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (in_valid) state_d = ST_FULL;
			end
			ST_FULL: begin
				if (out_ready && !in_valid) state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	// outputs: a new word may enter whenever the result register is free this cycle
	always_comb begin
		out_valid = 1'b0;
		in_ready  = 1'b1;
		case (state_q)
			ST_EMPTY: begin
				out_valid = 1'b0;
				in_ready  = 1'b1;
			end
			ST_FULL: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
			end
			default: begin
				out_valid = 1'b0;
				in_ready  = 1'b1;
			end
		endcase
		cmd.load = in_valid && in_ready;
	end

endmodule : sar_ctrl
`default_nettype wire

[hdl/sar_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sar_datapath: scroll and register datapath
// Holds the register file and scroll addresses and the result register.
// ----------------------------------------------------------------------------
module sar_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sar_pkg::dp_cmd_t            cmd,
	input  wire logic [1:0]                  command,
	input  wire logic [4:0]                  reg_offset,
	input  wire logic [7:0]                  write_data,
	output logic [7:0]                       read_data,
	output logic [sar_pkg::AddrW-1:0]        vram_address,
	output logic [sar_pkg::AddrW-1:0]        temp_address,
	output logic [2:0]                       fine_x,
	output logic                             write_toggle,
	output logic [7:0]                       control_value,
	output logic [7:0]                       mask_value
);
	import sar_pkg::*;

	logic [AddrW-1:0] cur_q, tmp_q, cur_d, tmp_d;
	logic [2:0]       finex_q, finex_d;
	logic             toggle_q, toggle_d;
	logic [7:0]       ctrl_q, ctrl_d, mask_q, mask_d;
	logic [7:0]       oamaddr_q, oamaddr_d, oamdata_q, oamdata_d;
	logic [7:0]       data_q, data_d, dma_q, dma_d;
	logic [7:0]       rd_d;
	logic [7:0]       rd_q;
	logic [15:0]      ysum;
	logic [AddrW-1:0] ystep;
	logic [AddrW-1:0] xstep;

	// coarse X step with horizontal nametable flip
	always_comb begin
		if (cur_q[4:0] == 5'h1f) begin
			xstep = (cur_q & 15'h7fe0) ^ 15'h0400;
		end else begin
			xstep = cur_q + 15'd1;
		end
	end

	// Y step: fine Y carries into coarse Y, row 29 flips vertical nametable
	always_comb begin
		ysum = {1'b0, cur_q} + 16'h1000;
		if (ysum[15]) begin
			if (ysum[9:5] == 5'd31) begin
				ystep = ysum[14:0] & 15'h7c1f;
			end else if (ysum[9:5] == 5'd29) begin
				ystep = (ysum[14:0] & 15'h7c1f) ^ 15'h0800;
			end else begin
				ystep = ysum[14:0] + 15'h0020;
			end
		end else begin
			ystep = ysum[14:0];
		end
	end

	// next register state for the current word
	always_comb begin
		cur_d     = cur_q;
		tmp_d     = tmp_q;
		finex_d   = finex_q;
		toggle_d  = toggle_q;
		ctrl_d    = ctrl_q;
		mask_d    = mask_q;
		oamaddr_d = oamaddr_q;
		oamdata_d = oamdata_q;
		data_d    = data_q;
		dma_d     = dma_q;
		rd_d      = 8'h00;
		case (command_t'(command))
			CMD_WRITE: begin
				case (reg_offset)
					OFF_CONTROL: begin
						ctrl_d = write_data;
						tmp_d  = (tmp_q & 15'h73ff) | {3'b000, write_data[1:0], 10'h000};
					end
					OFF_MASK:    mask_d    = write_data;
					OFF_OAMADDR: oamaddr_d = write_data;
					OFF_OAMDATA: oamdata_d = write_data;
					OFF_SCROLL: begin
						if (toggle_q) begin
							tmp_d = (tmp_q & 15'h0c1f) | {write_data[2:0], 2'b00,
								write_data[7:3], 5'h00};
						end else begin
							tmp_d   = (tmp_q & 15'h7fe0) | {10'h000, write_data[7:3]};
							finex_d = write_data[2:0];
						end
						toggle_d = !toggle_q;
					end
					OFF_ADDRESS: begin
						if (toggle_q) begin
							tmp_d = (tmp_q & 15'h7f00) | {7'h00, write_data};
							cur_d = (tmp_q & 15'h7f00) | {7'h00, write_data};
						end else begin
							tmp_d = (tmp_q & 15'h00ff) | {1'b0, write_data[5:0], 8'h00};
						end
						toggle_d = !toggle_q;
					end
					OFF_DATA: data_d = write_data;
					OFF_DMA:  dma_d  = write_data;
					default: ;
				endcase
			end
			CMD_READ: begin
				case (reg_offset)
					OFF_STATUS:  toggle_d = 1'b0;
					OFF_OAMDATA: rd_d     = oamdata_q;
					OFF_DATA:    rd_d     = data_q;
					default: ;
				endcase
			end
			CMD_COARSEX: cur_d = xstep;
			CMD_INCY:    cur_d = ystep;
			default: ;
		endcase
	end

	// architectural state and read result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			tmp_q     <= '0;
			finex_q   <= '0;
			toggle_q  <= 1'b0;
			ctrl_q    <= '0;
			mask_q    <= '0;
			oamaddr_q <= '0;
			oamdata_q <= '0;
			data_q    <= '0;
			dma_q     <= '0;
			rd_q      <= '0;
		end else if (cmd.load) begin
			cur_q     <= cur_d;
			tmp_q     <= tmp_d;
			finex_q   <= finex_d;
			toggle_q  <= toggle_d;
			ctrl_q    <= ctrl_d;
			mask_q    <= mask_d;
			oamaddr_q <= oamaddr_d;
			oamdata_q <= oamdata_d;
			data_q    <= data_d;
			dma_q     <= dma_d;
			rd_q      <= rd_d;
		end
	end

	// state registers double as the result word; they only change on a load
	assign read_data     = rd_q;
	assign vram_address  = cur_q;
	assign temp_address  = tmp_q;
	assign fine_x        = finex_q;
	assign write_toggle  = toggle_q;
	assign control_value = ctrl_q;
	assign mask_value    = mask_q;

endmodule : sar_datapath
`default_nettype wire

[hdl/scroll_address_register_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Latency: a result word is valid in the cycle after its command word is accepted.
// Throughput: one word per cycle; in_ready drops only while a result waits on out_ready.
// The whole update is one pass of shallow bit-field logic into the state registers.
// Reset: arst_n clears all scroll, register and handshake state to zero at once.
// ----------------------------------------------------------------------------
// scroll_address_register_unit: video chip scroll address registers
// Register writes and reads, coarse X and Y increments of the VRAM address.
// ----------------------------------------------------------------------------
module scroll_address_register_unit (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             command,
	input  wire logic [4:0]             reg_offset,
	input  wire logic [7:0]             write_data,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [7:0]                  read_data,
	output logic [sar_pkg::AddrW-1:0]   vram_address,
	output logic [sar_pkg::AddrW-1:0]   temp_address,
	output logic [2:0]                  fine_x,
	output logic                        write_toggle,
	output logic [7:0]                  control_value,
	output logic [7:0]                  mask_value
);
	import sar_pkg::*;

	dp_cmd_t cmd;

	// handshake controller
	sar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// register datapath
	sar_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.command       (command),
		.reg_offset    (reg_offset),
		.write_data    (write_data),
		.read_data     (read_data),
		.vram_address  (vram_address),
		.temp_address  (temp_address),
		.fine_x        (fine_x),
		.write_toggle  (write_toggle),
		.control_value (control_value),
		.mask_value    (mask_value)
	);

endmodule : scroll_address_register_unit
`default_nettype wire

[hdl/sar_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sar_checker: port-level checks of the scroll address register unit
// Watches the handshake and result words over time; bound to the top level.
// ----------------------------------------------------------------------------
module sar_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic [1:0]             command,
	input wire logic [4:0]             reg_offset,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [7:0]             read_data,
	input wire logic [sar_pkg::AddrW-1:0] vram_address,
	input wire logic                   write_toggle
);
	import sar_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// every accepted word yields a result word next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("no result after accepted word");

	// only reads return data
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (command != CMD_READ) |=> (read_data == 8'h00))
		else $error("read_data non-zero for non-read command");

	// status read clears the toggle and reads zero
	a_status_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (command == CMD_READ) && (reg_offset == OFF_STATUS)
		|=> (read_data == 8'h00) && !write_toggle)
		else $error("status read did not clear toggle");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vram_address))
		else $error("result changed while stalled");

endmodule : sar_checker

bind scroll_address_register_unit sar_checker u_sar_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.command      (command),
	.reg_offset   (reg_offset),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_data    (read_data),
	.vram_address (vram_address),
	.write_toggle (write_toggle)
);
`default_nettype wire
